>>> hdl/plcd_pkg.sv
// Shared types and constants for the press length decimal counter.
// Used by the phase tracker, the digit cells and the top level; no dependencies.
package plcd_pkg;

    // Number of decimal digits in the press counter.
    localparam int DIGITS     = 9;
    localparam int DIGIT_W    = 4;
    localparam int BCD_W      = DIGITS * DIGIT_W;
    localparam int BIN_W      = 30;
    localparam int BCD_OUT_W  = 36;
    localparam int BCD_PAD_W  = (BCD_W > BCD_OUT_W) ? BCD_W : BCD_OUT_W;
    localparam int EV_W       = 2;
    localparam int S_TDATA_W  = 8;
    localparam int M_TDATA_W  = 72;
    localparam int M_PAD_W    = M_TDATA_W - EV_W - BIN_W - BCD_OUT_W;

    localparam int LONG_W     = 16;
    localparam int SETTLE_W   = 8;
    localparam int TICK_W     = 16;
    localparam int CFG_ADDR_W = 1;
    localparam int CFG_DATA_W = 16;

    localparam logic [DIGIT_W-1:0]    DIGIT_MAX = DIGIT_W'(9);
    localparam logic [LONG_W-1:0]     LONG_RESET = LONG_W'(200);
    localparam logic [SETTLE_W-1:0]   SETTLE_RESET = SETTLE_W'(2);

    // Configuration register indexes.
    localparam logic [CFG_ADDR_W-1:0] REG_LONG_PRESS = 1'b0;
    localparam logic [CFG_ADDR_W-1:0] REG_SETTLE     = 1'b1;

    typedef enum logic [EV_W-1:0] {
        EV_NONE  = 2'd0,
        EV_SHORT = 2'd1,
        EV_LONG  = 2'd2
    } event_t;

    typedef struct packed {
        logic [LONG_W-1:0]   long_press_ticks;
        logic [SETTLE_W-1:0] settle_ticks;
    } plcd_cfg_t;

endpackage

>>> hdl/plcd_phase.sv
// Press phase tracker: debounce windows, hold-time count and press classification.
// Depends on plcd_pkg.
module plcd_phase (
    input  logic                aclk,
    input  logic                aresetn,
    input  logic                step,
    input  logic                released,
    input  plcd_pkg::plcd_cfg_t cfg,
    output plcd_pkg::event_t    press_event
);
    import plcd_pkg::*;

    typedef enum logic [5:0] {
        PH_IDLE         = 6'b000001,
        PH_SETTLE_PRESS = 6'b000010,
        PH_HOLD         = 6'b000100,
        PH_WAIT_RELEASE = 6'b001000,
        PH_SETTLE_SHORT = 6'b010000,
        PH_SETTLE_LONG  = 6'b100000
    } phase_t;

    phase_t              phase_reg, phase_next;
    logic [TICK_W-1:0]   ticks_reg, ticks_next;
    logic [TICK_W-1:0]   ticks_inc;
    logic [TICK_W-1:0]   ticks_sat;
    logic [TICK_W-1:0]   settle_ext;
    logic                settle_zero;
    event_t              event_comb;

    assign ticks_inc   = ticks_reg + TICK_W'(1);
    assign ticks_sat   = (&ticks_reg) ? ticks_reg : ticks_inc;
    assign settle_ext  = TICK_W'(cfg.settle_ticks);
    assign settle_zero = (cfg.settle_ticks == '0);

    always_comb begin
        phase_next = phase_reg;
        ticks_next = ticks_reg;
        event_comb = EV_NONE;
        case (phase_reg)
            PH_SETTLE_PRESS: begin
                if (ticks_inc >= settle_ext) begin
                    phase_next = PH_HOLD;
                    ticks_next = '0;
                end else begin
                    ticks_next = ticks_inc;
                end
            end
            PH_HOLD: begin
                if (released) begin
                    ticks_next = '0;
                    if (settle_zero) begin
                        event_comb = EV_SHORT;
                        phase_next = PH_IDLE;
                    end else begin
                        phase_next = PH_SETTLE_SHORT;
                    end
                end else if (ticks_sat >= cfg.long_press_ticks) begin
                    phase_next = PH_WAIT_RELEASE;
                    ticks_next = '0;
                end else begin
                    ticks_next = ticks_sat;
                end
            end
            PH_WAIT_RELEASE: begin
                if (released) begin
                    ticks_next = '0;
                    if (settle_zero) begin
                        event_comb = EV_LONG;
                        phase_next = PH_IDLE;
                    end else begin
                        phase_next = PH_SETTLE_LONG;
                    end
                end
            end
            PH_SETTLE_SHORT, PH_SETTLE_LONG: begin
                if (ticks_inc >= settle_ext) begin
                    event_comb = (phase_reg == PH_SETTLE_LONG) ? EV_LONG : EV_SHORT;
                    phase_next = PH_IDLE;
                    ticks_next = '0;
                end else begin
                    ticks_next = ticks_inc;
                end
            end
            default: begin
                ticks_next = '0;
                phase_next = PH_IDLE;
                if (!released) begin
                    phase_next = settle_zero ? PH_HOLD : PH_SETTLE_PRESS;
                end
            end
        endcase
    end

    // The event is only meaningful on a tick that is actually taken.
    assign press_event = step ? event_comb : EV_NONE;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            phase_reg <= PH_IDLE;
            ticks_reg <= '0;
        end else if (step) begin
            phase_reg <= phase_next;
            ticks_reg <= ticks_next;
        end
    end

endmodule

>>> hdl/plcd_digit_cell.sv
// One BCD digit of the press counter; carries ripple to the next cell up.
// Depends on plcd_pkg.
module plcd_digit_cell (
    input  logic                            aclk,
    input  logic                            aresetn,
    input  logic                            clear,
    input  logic                            carry_in,
    output logic                            carry_out,
    output logic [plcd_pkg::DIGIT_W-1:0]    digit
);
    import plcd_pkg::*;

    logic [DIGIT_W-1:0] digit_reg, digit_next;

    assign carry_out = carry_in && (digit_reg == DIGIT_MAX);

    always_comb begin
        digit_next = digit_reg;
        if (clear) begin
            digit_next = '0;
        end else if (carry_in) begin
            digit_next = (digit_reg == DIGIT_MAX) ? '0 : digit_reg + DIGIT_W'(1);
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            digit_reg <= '0;
        end else begin
            digit_reg <= digit_next;
        end
    end

    assign digit = digit_reg;

endmodule

>>> hdl/press_length_decimal_counter.sv
// Top level of the press length decimal counter: stream ports, configuration,
// the phase tracker and the row of BCD digit cells. Depends on plcd_pkg.
//
// Each input request is one sample of an active-low push button. The block
// takes one request per clock cycle, back to back unless stalled, and returns
// exactly one result for each, in the next cycle, in order. A press is debounced
// for settle_ticks samples at press and at release; a press released before
// long_press_ticks held samples is short and adds one to a nine-digit decimal
// counter that wraps from all nines to zero, and a longer press clears the
// counter. The event is reported on the last sample of the release settle
// window, or on the release sample itself when settle_ticks is zero. Each
// result carries the event and the counter value after that sample, in binary
// and in packed BCD. The throughput of one sample per cycle rests on the carry
// ripple through the digit cells and the binary increment being combinational.
// The result sits in an output register; while it waits, a new sample is still
// taken in the same cycle that the result is taken. Configuration writes take
// effect on the next sample and should be made while the block is idle. No
// clearing pass is needed after reset.
module press_length_decimal_counter (
    input  logic                               aclk,
    input  logic                               aresetn,

    // Configuration write port.
    input  logic                               cfg_wr_en,
    input  logic [plcd_pkg::CFG_ADDR_W-1:0]    cfg_addr,
    input  logic [plcd_pkg::CFG_DATA_W-1:0]    cfg_wdata,

    // Sample stream.
    input  logic                               s_tvalid,
    output logic                               s_tready,
    input  logic [plcd_pkg::S_TDATA_W-1:0]     s_tdata,   // [0] button_level

    // Result stream.
    output logic                               m_tvalid,
    input  logic                               m_tready,
    output logic [plcd_pkg::M_TDATA_W-1:0]     m_tdata    // [1:0] press_event,
                                                          // [31:2] count_binary,
                                                          // [67:32] count_bcd
);
    import plcd_pkg::*;

    plcd_cfg_t           cfg_reg;
    logic                s_accept;
    event_t              press_event;
    logic                m_tvalid_reg;
    event_t              event_reg;
    logic [BIN_W-1:0]    count_binary_reg, count_binary_next;
    logic [DIGITS:0]     carry;
    logic [BCD_W-1:0]    digits_flat;
    logic [BCD_PAD_W-1:0] bcd_padded;
    logic                count_inc;
    logic                count_clear;

    // Configuration registers, written whenever the write enable is high.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cfg_reg.long_press_ticks <= LONG_RESET;
            cfg_reg.settle_ticks     <= SETTLE_RESET;
        end else if (cfg_wr_en) begin
            case (cfg_addr)
                REG_LONG_PRESS: cfg_reg.long_press_ticks <= cfg_wdata[LONG_W-1:0];
                REG_SETTLE:     cfg_reg.settle_ticks     <= cfg_wdata[SETTLE_W-1:0];
                default:        cfg_reg <= cfg_reg;
            endcase
        end
    end

    // A new sample is taken whenever the output register is free or being drained.
    assign s_tready = !m_tvalid_reg || m_tready;
    assign s_accept = s_tvalid && s_tready;

    plcd_phase u_phase (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .step        (s_accept),
        .released    (s_tdata[0]),
        .cfg         (cfg_reg),
        .press_event (press_event)
    );

    // The phase tracker gates its event with the accept, so these are one-cycle pulses.
    assign count_inc   = (press_event == EV_SHORT);
    assign count_clear = (press_event == EV_LONG);

    // Row of digit cells; the increment enters at the least significant digit.
    assign carry[0] = count_inc;

    for (genvar i = 0; i < DIGITS; i++) begin : g_digit
        plcd_digit_cell u_cell (
            .aclk      (aclk),
            .aresetn   (aresetn),
            .clear     (count_clear),
            .carry_in  (carry[i]),
            .carry_out (carry[i+1]),
            .digit     (digits_flat[i*DIGIT_W +: DIGIT_W])
        );
    end

    // A carry out of the top cell means the counter was all nines and wraps to zero.
    always_comb begin
        count_binary_next = count_binary_reg;
        if (count_clear || carry[DIGITS]) begin
            count_binary_next = '0;
        end else if (count_inc) begin
            count_binary_next = count_binary_reg + BIN_W'(1);
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            count_binary_reg <= '0;
        end else begin
            count_binary_reg <= count_binary_next;
        end
    end

    // Output register. The counter only moves on an accepted sample, which also
    // reloads this register, so the counter state is the pending result's count.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_tvalid_reg <= 1'b0;
        end else if (s_accept) begin
            m_tvalid_reg <= 1'b1;
        end else if (m_tready) begin
            m_tvalid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (s_accept) begin
            event_reg <= press_event;
        end
    end

    assign bcd_padded = BCD_PAD_W'(digits_flat);
    assign m_tvalid   = m_tvalid_reg;
    assign m_tdata    = {{M_PAD_W{1'b0}}, bcd_padded[BCD_OUT_W-1:0], count_binary_reg,
                         event_reg};

endmodule
